// ===== design/date_time_advance_core_macros.svh =====
// Assertion macros for the date/time advance core.
// Used by date_time_advance_core only; no package dependency.
`ifndef DATE_TIME_ADVANCE_CORE_MACROS_SVH
`define DATE_TIME_ADVANCE_CORE_MACROS_SVH

// same-cycle implication
`define DTA_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dta_pkg.sv =====
// Package for the date/time advance core: payload structs, calendar state,
// divider constants and the month length table. No dependencies.
`default_nettype none

package dta_pkg;

    typedef struct packed {
        logic [26:0] start_date;
        logic [19:0] start_time;
        logic [15:0] step_count;
        logic [16:0] step_seconds;
    } cmd_t;

    typedef struct packed {
        logic [26:0] new_date;
        logic [17:0] new_time;
        logic [1:0]  status;
    } result_t;

    // year held as century and year-of-century
    typedef struct packed {
        logic [7:0]  century;
        logic [6:0]  yy;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [17:0] rem;
    } cal_t;

    typedef struct packed {
        logic finished;
        logic bad_month;
        logic overflow;
    } carry_flags_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;

    localparam logic [26:0] SAT_DATE   = 27'd99991231;
    localparam logic [7:0]  CENT_LIMIT = 8'd100;

    // divider operations, in sequencing order
    localparam logic [2:0] OP_SEC      = 3'd0;
    localparam logic [2:0] OP_MIN      = 3'd1;
    localparam logic [2:0] OP_DAY      = 3'd2;
    localparam logic [2:0] OP_MONTH    = 3'd3;
    localparam logic [2:0] OP_YEAR     = 3'd4;
    localparam logic [2:0] OP_DAYS     = 3'd5;
    localparam logic [2:0] OP_OSEC     = 3'd6;
    localparam logic [2:0] OP_OMIN     = 3'd7;

    // floor(2^32 / D): quotient estimate low by at most one
    localparam logic [26:0] RECIP_100  = 27'd42949672;
    localparam logic [26:0] RECIP_675  = 27'd6362914;
    localparam logic [26:0] RECIP_60   = 27'd71582788;

    function automatic logic [9:0] div_const(input logic [2:0] op);
        logic [9:0] d;
        case (op)
            OP_DAYS:          d = 10'd675;
            OP_OSEC, OP_OMIN: d = 10'd60;
            default:          d = 10'd100;
        endcase
        return d;
    endfunction

    function automatic logic [26:0] div_recip(input logic [2:0] op);
        logic [26:0] m;
        case (op)
            OP_DAYS:          m = RECIP_675;
            OP_OSEC, OP_OMIN: m = RECIP_60;
            default:          m = RECIP_100;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        if (m == 4'd2)
            len = leap ? 5'd29 : 5'd28;
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
            len = 5'd30;
        else
            len = 5'd31;
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/date_time_advance_core.sv =====
// Date/time advance core: top level, sequencer and shared multiplier.
// Depends on dta_pkg, dta_day_carry and date_time_advance_core_macros.svh.
`default_nettype none
`include "date_time_advance_core_macros.svh"

// A transfer is taken when start is high and busy is low; busy then stays high
// until the result. The result appears on result for exactly one cycle with
// done high and cannot be held off, so it must be captured that cycle; a new
// start may be given in the same cycle. The time an item takes grows with J, the
// number of calendar carry steps: one per whole year carried from
// 1 January and one per month boundary otherwise (J is about 300 at most for
// the largest step products). Eight digit splits share one 27x27 multiplier,
// which also forms count x step; the calendar carry advances one month or year per cycle.
module date_time_advance_core (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  dta_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done,
    output dta_pkg::result_t  result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_MUL,
        S_DIV_FIX,
        S_NS_MUL,
        S_NS_ADD,
        S_CARRY,
        S_FINISH
    } state_t;

    state_t                 state_reg;
    logic                   done_reg;
    dta_pkg::result_t       result_reg;
    dta_pkg::cmd_t          cmd_reg;
    logic [2:0]             op_reg;
    logic [26:0]            x_reg;
    logic [53:0]            prod_reg;
    logic [18:0]            tod_reg;
    logic [6:0]             low_reg;
    logic [6:0]             sec_reg;
    logic [6:0]             min_reg;
    logic [6:0]             hour_reg;
    logic [1:0]             status_reg;
    dta_pkg::cal_t          cal_reg;

    logic [26:0]            mul_a;
    logic [26:0]            mul_b;
    logic [53:0]            mul_p;
    logic [9:0]             dvs;
    logic [21:0]            q0;
    logic [20:0]            qd_prod;
    logic [10:0]            r0;
    logic                   fix_ge;
    logic [21:0]            q_fix;
    logic [10:0]            r_fix;
    logic [18:0]            tod;
    logic [33:0]            total;
    logic [27:0]            date_sum;
    logic [17:0]            time_sum;
    dta_pkg::cal_t          cal_next;
    dta_pkg::carry_flags_t  flags;

    dta_day_carry u_carry (
        .cur   (cal_reg),
        .nxt   (cal_next),
        .flags (flags)
    );

    // shared multiplier: reciprocal step of the divider, or count x step
    always_comb
    begin
        if (state_reg == S_NS_MUL)
        begin
            mul_a = 27'(cmd_reg.step_count);
            mul_b = 27'(cmd_reg.step_seconds);
        end
        else
        begin
            mul_a = x_reg;
            mul_b = dta_pkg::div_recip(op_reg);
        end
    end

    assign mul_p = {27'd0, mul_a} * {27'd0, mul_b};

    // quotient correction: remainder lies below twice the divisor
    assign dvs     = dta_pkg::div_const(op_reg);
    assign q0      = prod_reg[53:32];
    assign qd_prod = 21'(q0[10:0]) * 21'(dvs);
    assign r0      = x_reg[10:0] - qd_prod[10:0];
    assign fix_ge  = r0 >= 11'(dvs);
    assign q_fix   = fix_ge ? q0 + 22'd1 : q0;
    assign r_fix   = fix_ge ? r0 - 11'(dvs) : r0;

    assign tod   = 19'(hour_reg) * 19'd3600 + 19'(min_reg) * 19'd60 + 19'(sec_reg);
    assign total = 34'(tod_reg) + prod_reg[33:0];

    assign date_sum = 28'(cal_reg.century) * 28'd1000000 + 28'(cal_reg.yy) * 28'd10000
                    + 28'(cal_reg.month) * 28'd100 + 28'(cal_reg.day);
    assign time_sum = 18'(hour_reg) * 18'd10000 + 18'(min_reg) * 18'd100 + 18'(sec_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        x_reg     <= 27'(cmd.start_time);
                        op_reg    <= dta_pkg::OP_SEC;
                        state_reg <= S_DIV_MUL;
                    end
                end
                S_DIV_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DIV_FIX;
                end
                S_DIV_FIX:
                begin
                    state_reg <= S_DIV_MUL;
                    op_reg    <= op_reg + 3'd1;
                    x_reg     <= 27'(q_fix);
                    case (op_reg)
                        dta_pkg::OP_SEC:   sec_reg <= r_fix[6:0];
                        dta_pkg::OP_MIN:
                        begin
                            min_reg  <= r_fix[6:0];
                            hour_reg <= q_fix[6:0];
                            x_reg    <= cmd_reg.start_date;
                        end
                        dta_pkg::OP_DAY:   cal_reg.day   <= r_fix[6:0];
                        dta_pkg::OP_MONTH: cal_reg.month <= r_fix[6:0];
                        dta_pkg::OP_YEAR:
                        begin
                            cal_reg.yy      <= r_fix[6:0];
                            cal_reg.century <= q_fix[7:0];
                            state_reg       <= S_NS_MUL;
                        end
                        dta_pkg::OP_DAYS:
                        begin
                            cal_reg.rem <= q_fix[17:0];
                            x_reg       <= 27'({r_fix[9:0], low_reg});
                        end
                        dta_pkg::OP_OSEC:  sec_reg <= r_fix[6:0];
                        dta_pkg::OP_OMIN:
                        begin
                            min_reg    <= r_fix[6:0];
                            hour_reg   <= q_fix[6:0];
                            status_reg <= dta_pkg::ST_OK;
                            state_reg  <= S_CARRY;
                        end
                        default:           state_reg <= S_IDLE;
                    endcase
                end
                S_NS_MUL:
                begin
                    prod_reg  <= mul_p;
                    tod_reg   <= tod;
                    state_reg <= S_NS_ADD;
                end
                S_NS_ADD:
                begin
                    x_reg     <= total[33:7];
                    low_reg   <= total[6:0];
                    op_reg    <= dta_pkg::OP_DAYS;
                    state_reg <= S_DIV_MUL;
                end
                S_CARRY:
                begin
                    if (flags.bad_month)
                    begin
                        status_reg <= dta_pkg::ST_BAD;
                        state_reg  <= S_FINISH;
                    end
                    else if (flags.overflow)
                    begin
                        status_reg <= dta_pkg::ST_OVF;
                        state_reg  <= S_FINISH;
                    end
                    else if (flags.finished)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cal_reg <= cal_next;
                    end
                end
                S_FINISH:
                begin
                    case (status_reg)
                        dta_pkg::ST_BAD: result_reg.new_date <= cmd_reg.start_date;
                        dta_pkg::ST_OVF: result_reg.new_date <= dta_pkg::SAT_DATE;
                        default:         result_reg.new_date <= date_sum[26:0];
                    endcase
                    result_reg.new_time <= time_sum;
                    result_reg.status   <= status_reg;
                    done_reg            <= 1'b1;
                    state_reg           <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `DTA_ASSERT_NOW(a_done_not_busy, clk, rst_n, done, !busy, "result strobe while busy")
    `DTA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "transfer not taken")
    `DTA_ASSERT_NOW(a_status_code, clk, rst_n, done, result.status == dta_pkg::ST_OK || result.status == dta_pkg::ST_BAD || result.status == dta_pkg::ST_OVF, "bad status code")
    `DTA_ASSERT_NOW(a_ovf_sat, clk, rst_n, done && result.status == dta_pkg::ST_OVF, result.new_date == dta_pkg::SAT_DATE, "overflow date not saturated")
    `DTA_ASSERT_NOW(a_time_range, clk, rst_n, done, result.new_time < 18'd240000, "time of day out of range")

endmodule

`default_nettype wire

// ===== design/dta_day_carry.sv =====
// One calendar carry step: jumps a whole year from 1 January, or to the 1st
// of the next month, or finishes the remainder; it flags a bad month. Uses dta_pkg.
`default_nettype none

module dta_day_carry (
    input  dta_pkg::cal_t         cur,
    output dta_pkg::cal_t         nxt,
    output dta_pkg::carry_flags_t flags
);

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [6:0]  need;
    logic        month_ok;
    logic [7:0]  cent_inc;
    logic [6:0]  yy_inc;
    logic        year_ovf;

    assign leap = ((cur.yy[1:0] == 2'd0) && (cur.yy != 7'd0))
               || ((cur.yy == 7'd0) && (cur.century[1:0] == 2'd0));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = dta_pkg::month_days(cur.month[3:0], leap);
    assign month_ok = (cur.month != 7'd0) && (cur.month <= 7'd12);
    assign need = (cur.day < 7'(mlen)) ? 7'(mlen) - cur.day + 7'd1 : 7'd1;

    assign cent_inc = (cur.yy == 7'd99) ? cur.century + 8'd1 : cur.century;
    assign yy_inc   = (cur.yy == 7'd99) ? 7'd0 : cur.yy + 7'd1;
    assign year_ovf = cent_inc >= dta_pkg::CENT_LIMIT;

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        if (cur.rem == 18'd0)
        begin
            flags.finished = 1'b1;
        end
        else if (!month_ok)
        begin
            flags.bad_month = 1'b1;
        end
        else if ((cur.month == 7'd1) && (cur.day == 7'd1) && (cur.rem >= 18'(ylen)))
        begin
            nxt.century    = cent_inc;
            nxt.yy         = yy_inc;
            nxt.rem        = cur.rem - 18'(ylen);
            flags.overflow = year_ovf;
        end
        else if (cur.rem >= 18'(need))
        begin
            nxt.rem = cur.rem - 18'(need);
            nxt.day = 7'd1;
            if (cur.month == 7'd12)
            begin
                nxt.month      = 7'd1;
                nxt.century    = cent_inc;
                nxt.yy         = yy_inc;
                flags.overflow = year_ovf;
            end
            else
            begin
                nxt.month = cur.month + 7'd1;
            end
        end
        else
        begin
            nxt.day = cur.day + cur.rem[6:0];
            nxt.rem = 18'd0;
        end
    end

endmodule

`default_nettype wire

// ===== verif/date_time_advance_checker.sv =====
`timescale 1ns / 100ps
// Checker for date_time_advance_core: predicts each result from the command
// transfers it sees and compares it with the result strobed out by the core.
// Depends on dta_pkg.
module date_time_advance_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  dta_pkg::cmd_t    cmd,
    input  logic             done,
    input  dta_pkg::result_t result,
    output int               error_count,
    output int               pending_count
);

    localparam longint unsigned SECS_PER_DAY = 86400;
    localparam int unsigned     LAST_YEAR    = 9999;
    localparam int              REPORT_LIMIT = 10;

    dta_pkg::result_t expected_q[$];
    int               mismatches = 0;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y,
                                                  input int unsigned m);
        int unsigned len;
        case (m)
            2:           len = leap_year(y) ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:     len = 31;
        endcase
        return len;
    endfunction

    // Whole days are carried a month at a time rather than a day at a time.
    function automatic dta_pkg::result_t advance_date_time(input dta_pkg::cmd_t c);
        longint unsigned  hhmmss, steps, step_len, total, days, to_next, sod;
        int unsigned      date_in, year, month, day, len;
        dta_pkg::result_t r;
        hhmmss   = c.start_time;
        steps    = c.step_count;
        step_len = c.step_seconds;
        date_in  = c.start_date;
        total    = (hhmmss / 10000) * 3600 + ((hhmmss / 100) % 100) * 60 + hhmmss % 100
                   + steps * step_len;
        days     = total / SECS_PER_DAY;
        sod      = total % SECS_PER_DAY;
        year     = date_in / 10000;
        month    = (date_in / 100) % 100;
        day      = date_in % 100;
        r.status = dta_pkg::ST_OK;
        while (days > 0 && r.status == dta_pkg::ST_OK)
        begin
            if (month < 1 || month > 12)
            begin
                r.status = dta_pkg::ST_BAD;
            end
            else
            begin
                len     = days_in_month(year, month);
                to_next = (day >= len) ? 1 : len - day + 1;
                if (days < to_next)
                begin
                    day  = day + int'(days);
                    days = 0;
                end
                else
                begin
                    days  = days - to_next;
                    day   = 1;
                    month = month + 1;
                    if (month > 12)
                    begin
                        month = 1;
                        year  = year + 1;
                        if (year > LAST_YEAR)
                            r.status = dta_pkg::ST_OVF;
                    end
                end
            end
        end
        if (r.status == dta_pkg::ST_BAD)
            r.new_date = c.start_date;
        else if (r.status == dta_pkg::ST_OVF)
            r.new_date = dta_pkg::SAT_DATE;
        else
            r.new_date = 27'(year * 10000 + month * 100 + day);
        r.new_time = 18'((sod / 3600) * 10000 + ((sod / 60) % 60) * 100 + sod % 60);
        return r;
    endfunction

    always @(posedge clk)
    begin : monitor
        dta_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no command outstanding: %s %0d %0d %0d",
                                 $realtime, "date/time/status", result.new_date,
                                 result.new_time, result.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.new_date !== result.new_date || want.new_time !== result.new_time
                        || want.status !== result.status)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch exp/act date %0d/%0d time %0d/%0d %s",
                                     $realtime, want.new_date, result.new_date,
                                     want.new_time, result.new_time,
                                     $sformatf("status %0d/%0d", want.status, result.status));
                    end
                end
            end
            if (start && !busy)
                expected_q.insert(expected_q.size(), advance_date_time(cmd));
            pending_count <= expected_q.size();
            error_count   <= mismatches;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for date_time_advance_core: clock, reset, command stimulus
// and verdict. Depends on dta_pkg, the core and date_time_advance_checker.
module tb;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_CMDS  = 1250;

    logic             clk;
    logic             rst_n;
    logic             start;
    dta_pkg::cmd_t    cmd;
    logic             busy;
    logic             done;
    dta_pkg::result_t result;
    int               error_count;
    int               pending_count;
    int               cycle_count = 0;
    int               cmd_index   = 0;

    date_time_advance_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    date_time_advance_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic dta_pkg::cmd_t pack_cmd(input int unsigned date_v,
                                               input int unsigned time_v,
                                               input int unsigned count_v,
                                               input int unsigned secs_v);
        dta_pkg::cmd_t c;
        c.start_date   = 27'(date_v);
        c.start_time   = 20'(time_v);
        c.step_count   = 16'(count_v);
        c.step_seconds = 17'(secs_v);
        return c;
    endfunction

    function automatic int unsigned ymd(input int unsigned y, input int unsigned m,
                                        input int unsigned d);
        return y * 10000 + m * 100 + d;
    endfunction

    function automatic int unsigned rand_time();
        return $urandom_range(0, 23) * 10000 + $urandom_range(0, 59) * 100
               + $urandom_range(0, 59);
    endfunction

    function automatic int unsigned rand_step_secs();
        int unsigned s;
        case ($urandom_range(0, 5))
            0:       s = 60;
            1:       s = 900;
            2:       s = 3600;
            3:       s = 21600;
            4:       s = 86400;
            default: s = $urandom_range(0, 86400);
        endcase
        return s;
    endfunction

    // leap-year boundaries come up more often than a flat draw would give
    function automatic int unsigned rand_year();
        int unsigned y;
        case ($urandom_range(0, 3))
            0:       y = $urandom_range(0, 2499) * 4;
            1:       y = $urandom_range(0, 99) * 100;
            2:       y = $urandom_range(0, 24) * 400;
            default: y = $urandom_range(0, 9999);
        endcase
        return y;
    endfunction

    // The first 20 of every 100 transfers go back to back; otherwise the gap
    // is counted either from the last transfer or from the core going idle.
    task automatic send_cmd(input dta_pkg::cmd_t c);
        int gap;
        bit burst;
        bit from_idle;
        burst     = (cmd_index % 100) < 20;
        gap       = burst ? 0 : $urandom_range(0, 9);
        from_idle = !burst && ($urandom_range(0, 2) == 0);
        cmd_index++;
        if (gap > 0 || from_idle)
        begin
            start <= 1'b0;
            if (from_idle)
                do @(posedge clk); while (busy);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
    endtask

    initial
    begin
        int          kind;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned count_v;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_cmd(pack_cmd(0, 0, 0, 0));
        send_cmd(pack_cmd(99991231, 995959, 65535, 86400));
        send_cmd(pack_cmd(20231301, 0, 0, 0));
        send_cmd(pack_cmd(20231301, 120000, 1, 86400));
        send_cmd(pack_cmd(20230015, 0, 2, 86400));
        send_cmd(pack_cmd(20230145, 0, 1, 86400));
        send_cmd(pack_cmd(20230200, 0, 3, 86400));
        send_cmd(pack_cmd(20240228, 0, 1, 86400));
        send_cmd(pack_cmd(19000228, 0, 1, 86400));
        send_cmd(pack_cmd(20000228, 0, 1, 86400));
        send_cmd(pack_cmd(21000228, 0, 2, 86400));
        send_cmd(pack_cmd(20231231, 230000, 1, 3600));
        send_cmd(pack_cmd(99991231, 0, 1, 86400));
        send_cmd(pack_cmd(99991130, 0, 31, 86400));
        send_cmd(pack_cmd(20230615, 235959, 1, 1));
        send_cmd(pack_cmd(20230615, 995959, 0, 0));
        send_cmd(pack_cmd(20230615, 0, 1, 86400));
        send_cmd(pack_cmd(20230615, 0, 65535, 1));
        send_cmd(pack_cmd(20000101, 0, 65535, 86400));
        send_cmd(pack_cmd(228, 0, 1, 86400));
        send_cmd(pack_cmd(101, 0, 400, 86400));
        send_cmd(pack_cmd(99991231, 995959, 0, 86400));

        // random
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                send_cmd(pack_cmd(ymd($urandom_range(1, 9999), $urandom_range(1, 12),
                                      $urandom_range(1, 28)),
                                  rand_time(), $urandom_range(0, 300), rand_step_secs()));
            end
            else if (kind < 60)
            begin
                d = 28 + $urandom_range(0, 3);
                m = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(1, 12);
                send_cmd(pack_cmd(ymd(rand_year(), m, d), rand_time(),
                                  $urandom_range(0, 40), rand_step_secs()));
            end
            else if (kind < 70)
            begin
                send_cmd(pack_cmd(ymd($urandom_range(1, 9999), $urandom_range(1, 12),
                                      $urandom_range(1, 31)),
                                  rand_time(), $urandom_range(0, 65535),
                                  $urandom_range(0, 86400)));
            end
            else if (kind < 80)
            begin
                count_v = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 800)
                                                     : $urandom_range(0, 65535);
                send_cmd(pack_cmd(ymd($urandom_range(9985, 9999), $urandom_range(1, 12),
                                      $urandom_range(1, 31)),
                                  rand_time(), count_v, rand_step_secs()));
            end
            else if (kind < 90)
            begin
                y = $urandom_range(0, 9999);
                if ($urandom_range(0, 1) == 0)
                begin
                    m = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(13, 99);
                    d = $urandom_range(0, 99);
                end
                else
                begin
                    m = $urandom_range(1, 12);
                    d = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(32, 99);
                end
                send_cmd(pack_cmd(ymd(y, m, d), $urandom_range(0, 995959),
                                  $urandom_range(0, 70), rand_step_secs()));
            end
            else
            begin
                send_cmd(pack_cmd($urandom_range(0, 99991231), $urandom_range(0, 995959),
                                  $urandom_range(0, 65535), $urandom_range(0, 86400)));
            end
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
